/* rtl/core/ci64alu_pkg.sv */
// Package with the transfer types, operation codes and status codes of the checked 64-bit ALU.
package ci64alu_pkg;

    localparam logic [2:0] FUNC_ADD = 3'd0;
    localparam logic [2:0] FUNC_SUB = 3'd1;
    localparam logic [2:0] FUNC_MUL = 3'd2;
    localparam logic [2:0] FUNC_DIV = 3'd3;
    localparam logic [2:0] FUNC_CMP = 3'd4;

    localparam logic [2:0] PRED_EQ = 3'd0;
    localparam logic [2:0] PRED_NE = 3'd1;
    localparam logic [2:0] PRED_LT = 3'd2;
    localparam logic [2:0] PRED_LE = 3'd3;
    localparam logic [2:0] PRED_GT = 3'd4;
    localparam logic [2:0] PRED_GE = 3'd5;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_OVERFLOW     = 3'd1;
    localparam logic [2:0] ST_DIV_ZERO     = 3'd2;
    localparam logic [2:0] ST_DIV_OVERFLOW = 3'd3;
    localparam logic [2:0] ST_BAD_PRED     = 3'd4;

    localparam int DIV_STAGES = 64;

    typedef struct packed {
        logic [2:0]         func;
        logic               wrap_mode;
        logic [2:0]         predicate;
        logic signed [63:0] operand_a;
        logic signed [63:0] operand_b;
    } in_t;

    typedef struct packed {
        logic signed [63:0] result_value;
        logic               condition;
        logic [2:0]         status;
    } out_t;

    typedef struct packed {
        logic        valid;
        logic [2:0]  func;
        logic        wrap;
        logic        neg;
        logic [2:0]  status;
        logic        cond;
        logic [63:0] value;
        logic [63:0] dvsr;
        logic [63:0] rem;
        logic [63:0] nq;
    } stage_t;

endpackage

/* rtl/core/checked_int64_alu.sv */
// Top level of the checked signed 64-bit ALU with its full-rate pipeline.
//
// Input transfers arrive on s_valid/s_ready with an in_t payload on s_data.
// Each one yields exactly one result transfer on m_valid/m_ready, in order.
// Add, subtract and compare finish in the entry stage; multiply runs through
// four 32x32 partial products and a 128-bit sum over three stages; divide
// runs a restoring divider that retires one quotient bit per stage over 64
// stages. All operations share one pipeline of stage registers followed by an
// output register, and every result passes through all of them.
// The pipeline takes one new item every cycle while the output is not stalled.
// When the receiver holds m_ready low with a result waiting, the whole
// pipeline freezes and s_ready falls in the same cycle; nothing is lost or
// repeated. Synchronous reset on aresetn low clears all valid bits; items in
// flight are dropped.
// Traps return a zero value with a nonzero status; compare returns its
// outcome on condition with a zero value.
module checked_int64_alu (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ci64alu_pkg::in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ci64alu_pkg::out_t m_data
);

    localparam int NST = ci64alu_pkg::DIV_STAGES + 1;

    logic adv;

    ci64alu_pkg::stage_t st_reg [NST];
    ci64alu_pkg::stage_t st_next [NST];

    logic [63:0]  pp_ll_reg, pp_lh_reg, pp_hl_reg, pp_hh_reg;
    logic [127:0] prod_reg;
    logic [127:0] prod_next;

    logic               m_valid_reg;
    ci64alu_pkg::out_t  m_data_reg;
    ci64alu_pkg::out_t  m_data_next;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    logic [63:0] ua, ub, sum_r, dif_r, mag_a, mag_b;
    logic        add_ovf, sub_ovf, lt, eq;

    always_comb begin
        ua      = s_data.operand_a;
        ub      = s_data.operand_b;
        sum_r   = ua + ub;
        dif_r   = ua - ub;
        add_ovf = ((ua ^ sum_r) & (ub ^ sum_r)) >> 63 != 64'd0;
        sub_ovf = ((ua ^ ub) & (ua ^ dif_r)) >> 63 != 64'd0;
        mag_a   = ua[63] ? (64'd0 - ua) : ua;
        mag_b   = ub[63] ? (64'd0 - ub) : ub;
        lt      = s_data.operand_a < s_data.operand_b;
        eq      = ua == ub;

        st_next[0]       = '0;
        st_next[0].valid = s_valid;
        st_next[0].func  = s_data.func;
        st_next[0].wrap  = s_data.wrap_mode;
        st_next[0].neg   = ua[63] ^ ub[63];
        st_next[0].status = ci64alu_pkg::ST_OK;
        st_next[0].dvsr  = mag_b;
        st_next[0].nq    = mag_a;
        st_next[0].rem   = '0;
        unique case (s_data.func)
            ci64alu_pkg::FUNC_ADD: begin
                if (!s_data.wrap_mode && add_ovf) begin
                    st_next[0].status = ci64alu_pkg::ST_OVERFLOW;
                end else begin
                    st_next[0].value = sum_r;
                end
            end
            ci64alu_pkg::FUNC_SUB: begin
                if (!s_data.wrap_mode && sub_ovf) begin
                    st_next[0].status = ci64alu_pkg::ST_OVERFLOW;
                end else begin
                    st_next[0].value = dif_r;
                end
            end
            ci64alu_pkg::FUNC_DIV: begin
                if (ub == 64'd0) begin
                    st_next[0].status = ci64alu_pkg::ST_DIV_ZERO;
                end else if (ua == 64'h8000_0000_0000_0000 && ub == '1) begin
                    st_next[0].status = ci64alu_pkg::ST_DIV_OVERFLOW;
                end
            end
            ci64alu_pkg::FUNC_CMP: begin
                unique case (s_data.predicate)
                    ci64alu_pkg::PRED_EQ: st_next[0].cond = eq;
                    ci64alu_pkg::PRED_NE: st_next[0].cond = !eq;
                    ci64alu_pkg::PRED_LT: st_next[0].cond = lt;
                    ci64alu_pkg::PRED_LE: st_next[0].cond = lt || eq;
                    ci64alu_pkg::PRED_GT: st_next[0].cond = !lt && !eq;
                    ci64alu_pkg::PRED_GE: st_next[0].cond = !lt;
                    default: st_next[0].status = ci64alu_pkg::ST_BAD_PRED;
                endcase
            end
            default: begin
                st_next[0].status = ci64alu_pkg::ST_OK;
            end
        endcase
    end

    always_comb begin
        prod_next = {pp_hh_reg, pp_ll_reg}
                  + {32'd0, pp_lh_reg, 32'd0}
                  + {32'd0, pp_hl_reg, 32'd0};
    end

    logic [63:0] mul_lo, mul_val;
    logic        mul_ovf;

    always_comb begin
        mul_lo  = prod_reg[63:0];
        mul_val = st_reg[2].neg ? (64'd0 - mul_lo) : mul_lo;
        mul_ovf = (prod_reg[127:64] != 64'd0)
               || (st_reg[2].neg ? (mul_lo > 64'h8000_0000_0000_0000) : mul_lo[63]);
    end

    genvar gi;
    generate
        for (gi = 1; gi < NST; gi++) begin : g_div
            logic [64:0]         sh, diff;
            logic                qbit;
            ci64alu_pkg::stage_t stm;
            always_comb begin
                sh       = {st_reg[gi-1].rem, st_reg[gi-1].nq[63]};
                diff     = sh - {1'b0, st_reg[gi-1].dvsr};
                qbit     = !diff[64];
                stm      = st_reg[gi-1];
                stm.rem  = qbit ? diff[63:0] : sh[63:0];
                stm.nq   = {st_reg[gi-1].nq[62:0], qbit};
                st_next[gi] = stm;
                if (gi == 3 && st_reg[gi-1].func == ci64alu_pkg::FUNC_MUL) begin
                    if (!st_reg[gi-1].wrap && mul_ovf) begin
                        st_next[gi].status = ci64alu_pkg::ST_OVERFLOW;
                        st_next[gi].value  = '0;
                    end else begin
                        st_next[gi].value = mul_val;
                    end
                end
            end
        end
    endgenerate

    always_comb begin
        m_data_next.result_value = st_reg[NST-1].value;
        m_data_next.condition    = st_reg[NST-1].cond;
        m_data_next.status       = st_reg[NST-1].status;
        if (st_reg[NST-1].func == ci64alu_pkg::FUNC_DIV
                && st_reg[NST-1].status == ci64alu_pkg::ST_OK) begin
            m_data_next.result_value = st_reg[NST-1].neg
                ? (64'd0 - st_reg[NST-1].nq) : st_reg[NST-1].nq;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pp_ll_reg  <= 64'(st_reg[0].nq[31:0])  * 64'(st_reg[0].dvsr[31:0]);
            pp_lh_reg  <= 64'(st_reg[0].nq[31:0])  * 64'(st_reg[0].dvsr[63:32]);
            pp_hl_reg  <= 64'(st_reg[0].nq[63:32]) * 64'(st_reg[0].dvsr[31:0]);
            pp_hh_reg  <= 64'(st_reg[0].nq[63:32]) * 64'(st_reg[0].dvsr[63:32]);
            prod_reg   <= prod_next;
            m_data_reg <= m_data_next;
        end
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NST; i++) begin
                st_reg[i] <= '0;
            end
        end else if (adv) begin
            m_valid_reg <= st_reg[NST-1].valid;
            for (int i = 0; i < NST; i++) begin
                st_reg[i] <= st_next[i];
            end
        end
    end

`ifndef SYNTH
    a_trap_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ci64alu_pkg::ST_OK |-> m_data.result_value == 64'sd0
        && !m_data.condition)
        else $error("trapped result carries a value");

    a_cond_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.condition |-> m_data.status == ci64alu_pkg::ST_OK
        && m_data.result_value == 64'sd0)
        else $error("compare outcome with value or status");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status <= ci64alu_pkg::ST_BAD_PRED)
        else $error("status code out of range");

    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(st_reg[0].nq) && m_valid)
        else $error("pipeline moved during output stall");
`endif

endmodule
